[hw/rtl/rgsd_pkg.sv]
// Shared types and constants for the run-length sprite line decoder.
`default_nettype none
package rgsd_pkg;

	// Default parameter values
	localparam int TENTACLES_DEF = 8;
	localparam int HEAD_PART_DEF = 9;

	// Fixed field widths
	localparam int BYTE_W  = 8;
	localparam int PCT_W   = 7;
	localparam int ORG_W   = 9;
	localparam int ROW_W   = 9;
	localparam int COL_W   = 10;
	localparam int SCR_W   = 10;
	localparam int LEN_W   = 8;
	localparam int COLR_W  = 16;
	localparam int LIT_W   = 4;
	localparam int PROD_W  = 11;
	localparam int PCT_FULL = 100;

	// Command queue depth, a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration register indexes
	localparam logic REG_ORIGIN_X = 1'b0;
	localparam logic REG_ORIGIN_Y = 1'b1;

	// One decoded run, waiting to be drawn
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [LEN_W-1:0]  len;
		logic [COLR_W-1:0] lit;
		logic [COLR_W-1:0] dim;
		logic              on;
	} cmd_t;

endpackage
`default_nettype wire

[hw/rtl/rgsd_parser.sv]
// Front end: walks the sprite byte stream and classifies each finished run.
`default_nettype none
module rgsd_parser #(
	parameter int TENTACLES = rgsd_pkg::TENTACLES_DEF,
	parameter int HEAD_PART = rgsd_pkg::HEAD_PART_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        take,
	input  wire logic [rgsd_pkg::BYTE_W-1:0] data_byte,
	input  wire logic                        frame_start,
	input  wire logic [rgsd_pkg::PCT_W-1:0]  speed_pct,
	output logic                             push,
	output rgsd_pkg::cmd_t                   push_cmd
);
	import rgsd_pkg::*;

	typedef enum logic [6:0] {
		PH_COUNT  = 7'b0000001,
		PH_LEN    = 7'b0000010,
		PH_PART   = 7'b0000100,
		PH_LIT_LO = 7'b0001000,
		PH_LIT_HI = 7'b0010000,
		PH_DIM_LO = 7'b0100000,
		PH_DIM_HI = 7'b1000000
	} phase_t;

	phase_t              phase_q;
	logic [BYTE_W-1:0]   runs_left_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [LIT_W-1:0]    lit_level_q;
	logic [LEN_W-1:0]    len_q;
	logic [BYTE_W-1:0]   part_q;
	logic [COLR_W-1:0]   lit_q;
	logic [BYTE_W-1:0]   dim_lo_q;
	logic                on;

	// Ceiling of percent times tentacles over one hundred, clamped to tentacles
	function automatic logic [LIT_W-1:0] lit_of(input logic [PCT_W-1:0] fp);
		logic [PROD_W-1:0] prod;
		logic [LIT_W-1:0]  n;
		prod = PROD_W'(fp) * PROD_W'(TENTACLES);
		n = '0;
		for (int k = 1; k <= TENTACLES; k++) begin
			if (prod > PROD_W'(PCT_FULL * (k - 1)))
				n = n + LIT_W'(1);
		end
		return n;
	endfunction

	// Classify the run: head part or parts up to the lit level are lit
	assign on = (part_q == BYTE_W'(HEAD_PART)) || (part_q <= BYTE_W'(lit_level_q));

	assign push = take && !frame_start && (phase_q == PH_DIM_HI) && (part_q != '0);
	assign push_cmd = '{col: col_q, row: row_q, len: len_q, lit: lit_q,
		dim: {data_byte, dim_lo_q}, on: on};

	// Advance the record state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_COUNT;
			runs_left_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
			lit_level_q <= '0;
			len_q       <= '0;
			part_q      <= '0;
			lit_q       <= '0;
			dim_lo_q    <= '0;
		end else if (take) begin
			if (frame_start) begin
				lit_level_q <= lit_of(speed_pct);
				col_q       <= '0;
				runs_left_q <= data_byte;
				if (data_byte == '0) begin
					row_q   <= ROW_W'(1);
					phase_q <= PH_COUNT;
				end else begin
					row_q   <= '0;
					phase_q <= PH_LEN;
				end
			end else begin
				case (phase_q)
					PH_LEN: begin
						len_q   <= data_byte;
						phase_q <= PH_PART;
					end
					PH_PART: begin
						part_q  <= data_byte;
						phase_q <= PH_LIT_LO;
					end
					PH_LIT_LO: begin
						lit_q[7:0] <= data_byte;
						phase_q    <= PH_LIT_HI;
					end
					PH_LIT_HI: begin
						lit_q[15:8] <= data_byte;
						phase_q     <= PH_DIM_LO;
					end
					PH_DIM_LO: begin
						dim_lo_q <= data_byte;
						phase_q  <= PH_DIM_HI;
					end
					PH_DIM_HI: begin
						runs_left_q <= runs_left_q - BYTE_W'(1);
						if (runs_left_q == BYTE_W'(1)) begin
							row_q   <= row_q + ROW_W'(1);
							col_q   <= '0;
							phase_q <= PH_COUNT;
						end else begin
							col_q   <= col_q + COL_W'(len_q);
							phase_q <= PH_LEN;
						end
					end
					default: begin
						// Run count byte
						col_q       <= '0;
						runs_left_q <= data_byte;
						if (data_byte == '0) begin
							row_q   <= row_q + ROW_W'(1);
							phase_q <= PH_COUNT;
						end else begin
							phase_q <= PH_LEN;
						end
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rgsd_queue.sv]
// Short command queue between the stream parser and the line emitter.
`default_nettype none
module rgsd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire rgsd_pkg::cmd_t push_cmd,
	output logic                full,
	output logic                avail,
	input  wire logic           pop,
	output rgsd_pkg::cmd_t      head
);
	import rgsd_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign avail = (count_q != '0);
	assign head  = slot_q[rd_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_cmd;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rgsd_emit.sv]
// Back end: holds the origin registers and builds the line command output.
`default_nettype none
module rgsd_emit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [rgsd_pkg::ORG_W-1:0]   cfg_data,
	input  wire logic                         avail,
	input  wire rgsd_pkg::cmd_t               head,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [rgsd_pkg::SCR_W-1:0]        line_x,
	output logic [rgsd_pkg::SCR_W-1:0]        line_y,
	output logic [rgsd_pkg::LEN_W-1:0]        line_len,
	output logic [rgsd_pkg::COLR_W-1:0]       line_color,
	output logic                              is_lit
);
	import rgsd_pkg::*;

	logic [ORG_W-1:0] origin_x_q;
	logic [ORG_W-1:0] origin_y_q;
	logic             out_valid_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= ORG_W'(60);
			origin_y_q <= ORG_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take the next command whenever the output register is free or draining
	assign pop = avail && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Place the line on screen and pick its colour
	always_ff @(posedge clk) begin
		if (pop) begin
			line_x     <= SCR_W'(origin_x_q) + head.col;
			line_y     <= SCR_W'(origin_y_q) + SCR_W'(head.row);
			line_len   <= head.len;
			line_color <= head.on ? head.lit : head.dim;
			is_lit     <= head.on;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rle_gauge_sprite_decoder.sv]
// Top level of the run-length sprite decoder for the fan gauge.
//
// Takes one sprite byte per cycle while in_ready is high and turns each
// finished six-byte run record with a nonzero part into one horizontal-line
// draw command. A byte is consumed in the cycle it is transferred; a command
// is queued with its run's last byte, then waits for out_ready in the output
// register. A four-entry command queue sits between the parser and the output
// register, so in_ready falls only when that queue is full while the output is
// stalled; as commands come at most once per six bytes, the input keeps one
// byte per cycle unless the output stalls for long. The lit level is latched
// from speed_pct on a frame_start byte. The user must write origin_x and
// origin_y via cfg_we, cfg_index and cfg_data only while idle, unchecked.
`default_nettype none
module rle_gauge_sprite_decoder #(
	parameter int TENTACLES = rgsd_pkg::TENTACLES_DEF,
	parameter int HEAD_PART = rgsd_pkg::HEAD_PART_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [rgsd_pkg::ORG_W-1:0]   cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [rgsd_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic                         frame_start,
	input  wire logic [rgsd_pkg::PCT_W-1:0]   speed_pct,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [rgsd_pkg::SCR_W-1:0]        line_x,
	output logic [rgsd_pkg::SCR_W-1:0]        line_y,
	output logic [rgsd_pkg::LEN_W-1:0]        line_len,
	output logic [rgsd_pkg::COLR_W-1:0]       line_color,
	output logic                              is_lit
);
	import rgsd_pkg::*;

	logic take;
	logic push;
	logic full;
	logic avail;
	logic pop;
	cmd_t push_cmd;
	cmd_t head;

	// Accept a byte whenever the queue has room
	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	rgsd_parser #(
		.TENTACLES (TENTACLES),
		.HEAD_PART (HEAD_PART)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.speed_pct   (speed_pct),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	rgsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.avail    (avail),
		.pop      (pop),
		.head     (head)
	);

	rgsd_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.avail      (avail),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_x     (line_x),
		.line_y     (line_y),
		.line_len   (line_len),
		.line_color (line_color),
		.is_lit     (is_lit)
	);

endmodule
`default_nettype wire
